// ===== hdl/mlre_pkg.sv =====
`timescale 1ns / 1ps

package mlre_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS     = 16;
    localparam int CFG_BITS        = 5;
    localparam int CH_FIELD_BITS   = 4;
    localparam int RUN_FIELD_BITS  = 32;
    localparam int DATA_FIELD_BITS = CH_FIELD_BITS + 2 * RUN_FIELD_BITS + 1;
    localparam int M_TDATA_BITS    = ((DATA_FIELD_BITS + 7) / 8) * 8;

    // defaults for the top level parameters
    localparam int DEF_CHANNELS   = 16;
    localparam int DEF_INDEX_BITS = 32;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(16);

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_bits;
        logic                   end_of_capture;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } qslot_t;

    typedef struct packed {
        logic [CH_FIELD_BITS-1:0]  channel;
        logic [RUN_FIELD_BITS-1:0] run_start;
        logic [RUN_FIELD_BITS-1:0] run_length;
        logic                      level;
        logic                      flushed;
        logic                      end_of_item;
    } record_t;

endpackage

// ===== hdl/mlre_front.sv =====
`timescale 1ns / 1ps

module mlre_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mlre_pkg::item_t s_item,
    output mlre_pkg::qslot_t q_out,
    input  logic            q_ready
);
    import mlre_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign s_ready     = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_out.valid = (count_reg != '0);
    assign q_out.item  = mem[rd_ptr_reg];

    assign push = s_valid && s_ready;
    assign pop  = q_out.valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= s_item;
        end
    end

endmodule

// ===== hdl/mlre_back.sv =====
`timescale 1ns / 1ps

module mlre_back #(
    parameter int CHANNELS   = mlre_pkg::DEF_CHANNELS,
    parameter int INDEX_BITS = mlre_pkg::DEF_INDEX_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mlre_pkg::CFG_BITS-1:0] cfg_wr_data,
    input  mlre_pkg::qslot_t              q_in,
    output logic                          q_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mlre_pkg::record_t             m_rec
);
    import mlre_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LIVE_W = CFG_BITS + 1;
    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CHANGE = 3'b010,
        ST_FLUSH  = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [CFG_BITS-1:0]     active_reg, active_next;
    logic [CHANNELS-1:0]     levels_reg, levels_next;
    logic [INDEX_BITS-1:0]   starts_reg [CHANNELS];
    logic [INDEX_BITS-1:0]   starts_next [CHANNELS];
    logic [INDEX_BITS-1:0]   idx_reg, idx_next;
    logic                    awaiting_reg, awaiting_next;
    logic                    eoc_reg, eoc_next;
    logic [CHANNELS-1:0]     pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    record_t                 out_rec_reg, out_rec_next;

    logic [LIVE_W-1:0]       live;
    logic [CHANNELS-1:0]     active_mask;
    logic [CHANNELS+SAMPLE_BITS-1:0] sample_pad;
    logic [CHANNELS-1:0]     now_bits;
    logic [CHANNELS-1:0]     changed;
    logic [CHANNELS-1:0]     pend_rest;
    logic [CH_W-1:0]         sel_idx;
    logic [INDEX_BITS-1:0]   sel_start;
    logic [INDEX_BITS-1:0]   idx_inc;
    logic [INDEX_BITS-1:0]   len_change;
    logic [INDEX_BITS-1:0]   len_flush;
    logic                    can_emit;
    logic                    emit;
    record_t                 rec;

    // active count clamped to 1..CHANNELS
    always_comb begin
        if (active_reg == '0) begin
            live = LIVE_W'(1);
        end else if ({1'b0, active_reg} > LIVE_W'(CHANNELS)) begin
            live = LIVE_W'(CHANNELS);
        end else begin
            live = {1'b0, active_reg};
        end
        for (int c = 0; c < CHANNELS; c++) begin
            active_mask[c] = (LIVE_W'(c) < live);
        end
    end

    // channels past the sample word read level 0
    assign sample_pad = {{CHANNELS{1'b0}}, q_in.item.sample_bits};
    assign now_bits   = sample_pad[CHANNELS-1:0];
    assign changed    = now_bits ^ levels_reg;

    always_comb begin
        sel_idx = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (pend_reg[c]) begin
                sel_idx = CH_W'(c);
            end
        end
    end

    assign pend_rest  = pend_reg & (pend_reg - CHANNELS'(1));
    assign sel_start  = starts_reg[sel_idx];
    assign idx_inc    = (idx_reg == IDX_MAX) ? idx_reg : idx_reg + INDEX_BITS'(1);
    assign len_change = idx_reg - sel_start;
    assign len_flush  = idx_inc - sel_start;
    assign can_emit   = !out_valid_reg || m_ready;

    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_rec   = out_rec_reg;

    always_comb begin
        state_next    = state_reg;
        active_next   = cfg_wr_en ? cfg_wr_data : active_reg;
        levels_next   = levels_reg;
        starts_next   = starts_reg;
        idx_next      = idx_reg;
        awaiting_next = awaiting_reg;
        eoc_next      = eoc_reg;
        pend_next     = pend_reg;
        emit          = 1'b0;
        rec           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_in.valid) begin
                    eoc_next = q_in.item.end_of_capture;
                    if (awaiting_reg) begin
                        // first sample only seeds
                        levels_next   = now_bits;
                        awaiting_next = 1'b0;
                        for (int c = 0; c < CHANNELS; c++) begin
                            starts_next[c] = idx_reg;
                        end
                    end else begin
                        // inactive channels track silently
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (changed[c] && !active_mask[c]) begin
                                levels_next[c] = now_bits[c];
                                starts_next[c] = idx_reg;
                            end
                        end
                    end
                    if (!awaiting_reg && (changed & active_mask) != '0) begin
                        pend_next  = changed & active_mask;
                        state_next = ST_CHANGE;
                    end else if (q_in.item.end_of_capture) begin
                        pend_next  = active_mask;
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next = idx_inc;
                    end
                end
            end
            ST_CHANGE: begin
                if (can_emit) begin
                    emit            = 1'b1;
                    rec.channel     = CH_FIELD_BITS'(sel_idx);
                    rec.run_start   = RUN_FIELD_BITS'(sel_start);
                    rec.run_length  = RUN_FIELD_BITS'(len_change);
                    rec.level       = levels_reg[sel_idx];
                    rec.flushed     = 1'b0;
                    rec.end_of_item = (pend_rest == '0) && !eoc_reg;
                    levels_next[sel_idx] = ~levels_reg[sel_idx];
                    starts_next[sel_idx] = idx_reg;
                    pend_next = pend_rest;
                    if (pend_rest == '0) begin
                        if (eoc_reg) begin
                            pend_next  = active_mask;
                            state_next = ST_FLUSH;
                        end else begin
                            idx_next   = idx_inc;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (can_emit) begin
                    emit            = 1'b1;
                    rec.channel     = CH_FIELD_BITS'(sel_idx);
                    rec.run_start   = RUN_FIELD_BITS'(sel_start);
                    rec.run_length  = RUN_FIELD_BITS'(len_flush);
                    rec.level       = levels_reg[sel_idx];
                    rec.flushed     = 1'b1;
                    rec.end_of_item = (pend_rest == '0);
                    pend_next = pend_rest;
                    if (pend_rest == '0) begin
                        // rearm for the next capture
                        idx_next      = '0;
                        awaiting_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
        out_rec_next = emit ? rec : out_rec_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= CFG_RESET;
            levels_reg    <= '0;
            idx_reg       <= '0;
            awaiting_reg  <= 1'b1;
            eoc_reg       <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            levels_reg    <= levels_next;
            idx_reg       <= idx_next;
            awaiting_reg  <= awaiting_next;
            eoc_reg       <= eoc_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        starts_reg  <= starts_next;
        out_rec_reg <= out_rec_next;
    end

endmodule

// ===== hdl/multichannel_logic_run_length_encoder.sv =====
`timescale 1ns / 1ps

// channel   dir  ports                          payload
// s_        in   s_tvalid s_tready s_tdata      sample_bits; s_tlast = end_of_capture
//                s_tlast
// m_        out  m_tvalid m_tready m_tdata      channel, run_start, run_length, level;
//                m_tuser m_tlast                m_tuser = flushed; m_tlast = end_of_item
// cfg_      in   cfg_wr_en cfg_wr_data          active_channels
//
// the back sequencer classifies an item in ST_IDLE, then emits its k records
// one record per cycle while the single record output register is empty or
// m_tready is high; after an item with no records it stays in ST_IDLE
// aresetn is synchronous and active low; it rearms the capture and sets
// active_channels to 16, no clearing pass is needed
// m_tready low holds a waiting record in the output register and stalls the
// sequencer's emit states; the two-entry queue keeps taking samples until it fills

module multichannel_logic_run_length_encoder #(
    parameter int CHANNELS   = mlre_pkg::DEF_CHANNELS,
    parameter int INDEX_BITS = mlre_pkg::DEF_INDEX_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write, no read-back
    input  logic                              cfg_wr_en,
    input  logic [mlre_pkg::CFG_BITS-1:0]     cfg_wr_data,   // active_channels
    // sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mlre_pkg::SAMPLE_BITS-1:0]  s_tdata,       // sample_bits[15:0]
    input  logic                              s_tlast,       // end_of_capture
    // run record stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // channel[3:0], run_start[35:4], run_length[67:36], level[68], zero pad
    output logic [mlre_pkg::M_TDATA_BITS-1:0] m_tdata,
    output logic                              m_tuser,       // flushed
    output logic                              m_tlast        // end_of_item
);
    import mlre_pkg::*;

    item_t   s_item;
    qslot_t  q_slot;
    logic    q_ready;
    record_t rec;

    assign s_item.sample_bits    = s_tdata;
    assign s_item.end_of_capture = s_tlast;

    // front: accepts sample transactions into the short queue
    mlre_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .q_out   (q_slot),
        .q_ready (q_ready)
    );

    // back: per-channel run state, change scan and flush sequencer
    mlre_back #(
        .CHANNELS   (CHANNELS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_in        (q_slot),
        .q_ready     (q_ready),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_rec       (rec)
    );

    // pack record fields, lowest field in the lowest bits
    assign m_tdata = M_TDATA_BITS'({rec.level, rec.run_length, rec.run_start, rec.channel});
    assign m_tuser = rec.flushed;
    assign m_tlast = rec.end_of_item;

endmodule

// ===== hdl/mlre_checker.sv =====
`timescale 1ns / 1ps

module mlre_checker #(
    parameter int CHANNELS = mlre_pkg::DEF_CHANNELS
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mlre_pkg::M_TDATA_BITS-1:0] m_tdata,
    input logic                              m_tuser,
    input logic                              m_tlast
);
    import mlre_pkg::*;

    // no record comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("record valid right after reset");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("record dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("record changed while stalled");

    // flush of the highest possible channel closes the item
    a_flush_top_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (CHANNELS <= 16) && m_tvalid && m_tuser && (m_tdata[3:0] == 4'hF) |-> m_tlast)
        else $error("flush of channel 15 not marked last");

endmodule

bind multichannel_logic_run_length_encoder mlre_checker #(
    .CHANNELS (CHANNELS)
) u_mlre_checker (.*);
